/* src/psmd_pkg.sv */
// psmd_pkg: shared types and constants for the pid speed motor drive
// payload structs, configuration indexes, gain defaults and scaling constants
// no dependencies
`default_nettype none

package psmd_pkg;

    localparam int GAIN_W  = 10;
    localparam int REF_W   = 11;
    localparam int COUNT_W = 16;
    localparam int LEVEL_W = 8;
    localparam int ERR_W   = 18;
    localparam int SUM_W   = 39;
    localparam int NUM_W   = 51;

    typedef struct packed {
        logic signed [REF_W-1:0]   speed_ref;
        logic signed [COUNT_W-1:0] encoder_count;
    } in_t;

    typedef struct packed {
        logic               drive_dir;
        logic [LEVEL_W-1:0] drive_level;
    } out_t;

    typedef enum logic [1:0] {
        CFG_KP = 2'd0,
        CFG_KI = 2'd1,
        CFG_KD = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ZONE_DEAD = 2'd0,
        ZONE_POS  = 2'd1,
        ZONE_NEG  = 2'd2
    } zone_t;

    localparam logic [GAIN_W-1:0] DEF_KP = 10'd120;
    localparam logic [GAIN_W-1:0] DEF_KI = 10'd50;
    localparam logic [GAIN_W-1:0] DEF_KD = 10'd5;

    localparam logic signed [ERR_W-1:0] ERR_THRESH  = 18'sd250;
    localparam logic signed [ERR_W-1:0] SPEED_SCALE = 18'sd50;
    localparam logic [SUM_W-1:0]        SUM_MAX     = {SUM_W{1'b1}};

    // |e| / 50 as multiply by ceil(2^22/50), exact for |e| below 91180
    localparam logic [16:0] RECIP50     = 17'd83887;
    localparam int          DIV50_SHIFT = 22;

    localparam logic signed [NUM_W-1:0] P_SCALE     = 51'sd1000;
    localparam logic signed [37:0]      D_SCALE     = 38'sd400;
    localparam logic signed [NUM_W-1:0] OUT_DIVISOR = 51'sd100000;

    localparam logic [LEVEL_W-1:0] LEVEL_FALLBACK = 8'd150;
    localparam logic signed [NUM_W-1:0] LEVEL_SPAN = 51'sd25000000;

    // n / 100000 as multiply by ceil(2^42/100000), exact for n below 4.9e7
    localparam logic [25:0] RECIP_OUT = 26'd43980466;
    localparam int          OUT_SHIFT = 42;

endpackage

`default_nettype wire

/* src/psmd_level.sv */
// psmd_level: maps the scaled control sum to the dac drive level
// truncating divide by 100000 through a reciprocal, plus range fallback
// depends on psmd_pkg
`default_nettype none

module psmd_level (
    input  wire logic signed [psmd_pkg::NUM_W-1:0]   num,
    input  wire logic                                active,
    output logic             [psmd_pkg::LEVEL_W-1:0] level
);

    logic [psmd_pkg::NUM_W-1:0] prod;

    assign prod = psmd_pkg::NUM_W'(num[24:0]) * psmd_pkg::NUM_W'(psmd_pkg::RECIP_OUT);

    always_comb
    begin
        if (!active)
        begin
            level = '0;
        end
        else if (num < 0)
        begin
            // small negative sums truncate to zero
            if (num > -psmd_pkg::OUT_DIVISOR)
            begin
                level = '0;
            end
            else
            begin
                level = psmd_pkg::LEVEL_FALLBACK;
            end
        end
        else if (num >= psmd_pkg::LEVEL_SPAN)
        begin
            level = psmd_pkg::LEVEL_FALLBACK;
        end
        else
        begin
            level = psmd_pkg::LEVEL_W'(prod >> psmd_pkg::OUT_SHIFT);
        end
    end

endmodule

`default_nettype wire

/* src/pid_speed_motor_drive.sv */
// pid_speed_motor_drive: pipelined discrete pid speed controller
// six registered stages from encoder sample to dac level
// depends on psmd_pkg and psmd_level
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------
//  in      | in_valid / in_ready    | in_data    (speed_ref, encoder_count)
//  out     | out_valid / out_ready  | out_data   (drive_dir, drive_level)
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (gain write)
//
// one transaction per cycle unless the output stalls
// the very first sample after reset only latches the count and gives no result
// reset clears the counter history, error sum, previous error and direction
// a stalled output backs up stage by stage; the input keeps accepting while
// any stage ahead still has a free slot
`default_nettype none

module pid_speed_motor_drive (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire psmd_pkg::in_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output psmd_pkg::out_t       out_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [psmd_pkg::GAIN_W-1:0] cfg_data
);

    // configuration
    logic [psmd_pkg::GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [psmd_pkg::GAIN_W-1:0] kp_eff, ki_eff, kd_eff;
    logic                        gains_zero;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= '0;
            ki_reg <= '0;
            kd_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                psmd_pkg::CFG_KP: kp_reg <= cfg_data;
                psmd_pkg::CFG_KI: ki_reg <= cfg_data;
                psmd_pkg::CFG_KD: kd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign gains_zero = (kp_reg == '0) && (ki_reg == '0) && (kd_reg == '0);
    assign kp_eff = gains_zero ? psmd_pkg::DEF_KP : kp_reg;
    assign ki_eff = gains_zero ? psmd_pkg::DEF_KI : ki_reg;
    assign kd_eff = gains_zero ? psmd_pkg::DEF_KD : kd_reg;

    // stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic in_fire;

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign in_fire  = in_valid && in_ready;

    // controller state
    logic                               primed_reg;
    logic        [psmd_pkg::COUNT_W-1:0] last_count_reg;
    logic signed [psmd_pkg::ERR_W-1:0]  eprev_reg;
    logic        [psmd_pkg::SUM_W-1:0]  sum_reg;
    logic                               dir_reg;

    // stage 1: scaled error
    logic signed [psmd_pkg::COUNT_W-1:0] dx;
    logic signed [psmd_pkg::ERR_W-1:0]   e1_next, e1_reg;

    assign dx      = signed'(in_data.encoder_count - last_count_reg);
    assign e1_next = psmd_pkg::ERR_W'(in_data.speed_ref) * psmd_pkg::SPEED_SCALE
                   + psmd_pkg::ERR_W'(dx);

    // stage 2: integrator, derivative, zone
    logic                              pos, neg;
    logic [psmd_pkg::SUM_W:0]          sum_add;
    logic [psmd_pkg::SUM_W-1:0]        sum_next;
    logic signed [psmd_pkg::ERR_W:0]   diff_next;
    logic [psmd_pkg::ERR_W-2:0]        abs_next;
    psmd_pkg::zone_t                   zone_next;
    logic                              dir_next;

    assign pos     = e1_reg > psmd_pkg::ERR_THRESH;
    assign neg     = e1_reg < -psmd_pkg::ERR_THRESH;
    assign sum_add = (psmd_pkg::SUM_W+1)'(sum_reg) + (psmd_pkg::SUM_W+1)'(e1_reg);

    always_comb
    begin
        if (!pos)
        begin
            sum_next = '0;
        end
        else if (sum_add[psmd_pkg::SUM_W])
        begin
            sum_next = psmd_pkg::SUM_MAX;
        end
        else
        begin
            sum_next = sum_add[psmd_pkg::SUM_W-1:0];
        end
    end

    always_comb
    begin
        if (pos)
        begin
            zone_next = psmd_pkg::ZONE_POS;
            dir_next  = 1'b1;
        end
        else if (neg)
        begin
            zone_next = psmd_pkg::ZONE_NEG;
            dir_next  = 1'b0;
        end
        else
        begin
            zone_next = psmd_pkg::ZONE_DEAD;
            dir_next  = dir_reg;
        end
    end

    assign diff_next = (psmd_pkg::ERR_W+1)'(e1_reg) - (psmd_pkg::ERR_W+1)'(eprev_reg);
    assign abs_next  = (psmd_pkg::ERR_W-1)'(e1_reg[psmd_pkg::ERR_W-1] ? -e1_reg : e1_reg);

    logic        [psmd_pkg::ERR_W-2:0] abs2_reg;
    logic        [psmd_pkg::SUM_W-1:0] sum2_reg;
    logic signed [psmd_pkg::ERR_W:0]   diff2_reg;
    psmd_pkg::zone_t                   zone2_reg, zone3_reg, zone4_reg, zone5_reg, zone6_reg;
    logic                              dir2_reg, dir3_reg, dir4_reg, dir5_reg, dir6_reg;

    // stage 3: integral and derivative gain products, proportional product input
    logic [33:0]                   abs_prod;
    logic [10:0]                   absdiv3_next, absdiv3_reg;
    logic [48:0]                   pi3_next, pi3_reg, pi4_reg;
    logic signed [28:0]            pd3_next, pd3_reg;
    logic signed [psmd_pkg::GAIN_W:0] kd_s;

    assign abs_prod     = 34'(abs2_reg) * 34'(psmd_pkg::RECIP50);
    assign absdiv3_next = 11'(abs_prod >> psmd_pkg::DIV50_SHIFT);
    assign pi3_next     = 49'(ki_eff) * 49'(sum2_reg);
    assign kd_s         = signed'({1'b0, kd_eff});
    assign pd3_next     = 29'(kd_s) * 29'(diff2_reg);

    // stage 4
    logic [20:0]        pp4_next, pp4_reg;
    logic signed [37:0] pd4_next, pd4_reg;

    assign pp4_next = 21'(kp_eff) * 21'(absdiv3_reg);
    assign pd4_next = 38'(pd3_reg) * psmd_pkg::D_SCALE;

    // stage 5: numerator
    logic signed [psmd_pkg::NUM_W-1:0] num5_next, num5_reg;

    assign num5_next = signed'(psmd_pkg::NUM_W'(pp4_reg)) * psmd_pkg::P_SCALE
                     + signed'(psmd_pkg::NUM_W'(pi4_reg))
                     + psmd_pkg::NUM_W'(pd4_reg);

    // stage 6: level
    logic [psmd_pkg::LEVEL_W-1:0] level6_next, level6_reg;

    psmd_level u_level (
        .num    (num5_reg),
        .active (zone5_reg != psmd_pkg::ZONE_DEAD),
        .level  (level6_next)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
            v6_reg         <= 1'b0;
            primed_reg     <= 1'b0;
            last_count_reg <= '0;
            eprev_reg      <= '0;
            sum_reg        <= '0;
            dir_reg        <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_fire && primed_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
            if (in_fire)
            begin
                primed_reg     <= 1'b1;
                last_count_reg <= in_data.encoder_count;
            end
            // controller history moves once per transaction, in order
            if (rdy2 && v1_reg)
            begin
                eprev_reg <= e1_reg;
                sum_reg   <= sum_next;
                dir_reg   <= dir_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_fire) e1_reg <= e1_next;
        if (rdy2 && v1_reg)
        begin
            abs2_reg  <= abs_next;
            sum2_reg  <= sum_next;
            diff2_reg <= diff_next;
            zone2_reg <= zone_next;
            dir2_reg  <= dir_next;
        end
        if (rdy3 && v2_reg)
        begin
            absdiv3_reg <= absdiv3_next;
            pi3_reg     <= pi3_next;
            pd3_reg     <= pd3_next;
            zone3_reg   <= zone2_reg;
            dir3_reg    <= dir2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            pp4_reg   <= pp4_next;
            pi4_reg   <= pi3_reg;
            pd4_reg   <= pd4_next;
            zone4_reg <= zone3_reg;
            dir4_reg  <= dir3_reg;
        end
        if (rdy5 && v4_reg)
        begin
            num5_reg  <= num5_next;
            zone5_reg <= zone4_reg;
            dir5_reg  <= dir4_reg;
        end
        if (rdy6 && v5_reg)
        begin
            level6_reg <= level6_next;
            zone6_reg  <= zone5_reg;
            dir6_reg   <= dir5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = {dir6_reg, level6_reg};

    // checks
    a_primed_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> primed_reg)
        else $error("primed flag not set after a sample");

    a_dead_band_level: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg && (zone6_reg == psmd_pkg::ZONE_DEAD) |-> out_data.drive_level == '0)
        else $error("dead band result with nonzero level");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.drive_level < 8'd250)
        else $error("drive level out of range");

    a_dir_follows_zone: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg && (zone6_reg == psmd_pkg::ZONE_POS) |-> out_data.drive_dir)
        else $error("positive error did not drive right");

endmodule

`default_nettype wire
